### hw/rtl/rkx_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rolling-key XOR packet scrambler.
package rkx_pkg;

   // Default sizes, overridable on the top level
   localparam int KEY_STRING_BYTES_DEF  = 1024;
   localparam int MAX_MESSAGE_BYTES_DEF = 16384;

   // Header layout
   localparam int ENCODE_HEADER_BYTES = 12;
   localparam int DECODE_HEADER_BYTES = 4;
   localparam int SEED_MIX_POS        = 4;   // encode seed also folds in this byte

   localparam int BYTE_W  = 8;
   localparam int SKIP_W  = 4;
   localparam int START_W = 5;   // holds skip + decode header

   // Key-string character substitution
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;

   // Item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MSG  = 1'b1;

   // Mode register values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHALLENGE = 1'b1;

endpackage

### hw/rtl/rkx_key_store.sv
`timescale 1ns / 1ps
// Key-string memory: one write port, one registered read port, entry 0 shadow.
module rkx_key_store #(
   parameter int KEY_STRING_BYTES = rkx_pkg::KEY_STRING_BYTES_DEF,
   localparam int IDX_W = $clog2(KEY_STRING_BYTES)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [rkx_pkg::BYTE_W-1:0]  wr_data,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [rkx_pkg::BYTE_W-1:0]  rd_data,
   output logic [rkx_pkg::BYTE_W-1:0]  key0
);

   logic [rkx_pkg::BYTE_W-1:0] mem [KEY_STRING_BYTES];
   logic [rkx_pkg::BYTE_W-1:0] rd_data_ff;
   logic [rkx_pkg::BYTE_W-1:0] key0_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // write-first forwarding on a same-address collision
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // copy of entry 0, used when the index wraps
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         key0_ff <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;
   assign key0    = key0_ff;

endmodule

### hw/rtl/rkx_cipher_core.sv
`timescale 1ns / 1ps
// Scrambler state, key draw and per-byte transform.
module rkx_cipher_core #(
   parameter int KEY_STRING_BYTES  = rkx_pkg::KEY_STRING_BYTES_DEF,
   parameter int MAX_MESSAGE_BYTES = rkx_pkg::MAX_MESSAGE_BYTES_DEF,
   localparam int IDX_W = $clog2(KEY_STRING_BYTES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rkx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rkx_pkg::BYTE_W-1:0]    csr_wr_data,
   input  logic                          accept,
   input  logic                          op,
   input  logic [rkx_pkg::BYTE_W-1:0]    value,
   input  logic                          first,
   input  logic [rkx_pkg::SKIP_W-1:0]    start_skip,
   output logic [rkx_pkg::BYTE_W-1:0]    res_byte,
   output logic                          mem_wr_en,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output logic [rkx_pkg::BYTE_W-1:0]    mem_wr_data,
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  logic [rkx_pkg::BYTE_W-1:0]    mem_rd_data,
   input  logic [rkx_pkg::BYTE_W-1:0]    mem_key0
);

   localparam int LEN_W = $clog2(KEY_STRING_BYTES + 1);
   localparam int POS_W = $clog2(MAX_MESSAGE_BYTES);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(KEY_STRING_BYTES);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_MESSAGE_BYTES - 1);

   logic                         mode_ff, mode_in;
   logic [rkx_pkg::BYTE_W-1:0]   challenge_ff, challenge_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [rkx_pkg::BYTE_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [rkx_pkg::START_W-1:0]  start_ff, start_in;

   logic                         is_load, is_msg, draw, wrap;
   logic [LEN_W-1:0]             load_base, idx_step;
   logic [IDX_W-1:0]             idx_next;
   logic [POS_W-1:0]             pos_cur;
   logic [rkx_pkg::START_W-1:0]  start_cur;
   logic [rkx_pkg::BYTE_W-1:0]   raw_k, k, k_shift, key_mid, key_out;

   // config registers
   always_comb begin
      mode_in      = mode_ff;
      challenge_in = challenge_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rkx_pkg::CSR_MODE:      mode_in      = csr_wr_data[0];
            rkx_pkg::CSR_CHALLENGE: challenge_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      is_load = accept && (op == rkx_pkg::OP_LOAD);
      is_msg  = accept && (op == rkx_pkg::OP_MSG);

      // key-string load
      load_base   = first ? '0 : len_ff;
      mem_wr_en   = is_load && (load_base < LEN_FULL);
      mem_wr_addr = load_base[IDX_W-1:0];
      mem_wr_data = value;
      if (is_load) begin
         len_in = mem_wr_en ? load_base + LEN_W'(1) : load_base;
      end else begin
         len_in = len_ff;
      end

      // message position and start
      pos_cur = first ? '0 : pos_ff;
      if (first) begin
         start_cur = (mode_ff == rkx_pkg::MODE_DECODE)
                   ? rkx_pkg::START_W'(start_skip) + rkx_pkg::START_W'(rkx_pkg::DECODE_HEADER_BYTES)
                   : rkx_pkg::START_W'(rkx_pkg::ENCODE_HEADER_BYTES);
      end else begin
         start_cur = start_ff;
      end
      // start is never below the decode header, so a first byte never draws
      draw = is_msg && (pos_cur >= POS_W'(start_cur));

      // key draw: registered read data belongs to idx_ff
      wrap  = (LEN_W'(idx_ff) >= len_ff) || (mem_rd_data == '0);
      if (len_ff == '0) begin
         raw_k = '0;
      end else begin
         raw_k = wrap ? mem_key0 : mem_rd_data;
      end
      k = (raw_k == rkx_pkg::CHAR_PERCENT) ? rkx_pkg::CHAR_DOT : raw_k;
      idx_step = wrap ? LEN_W'(1) : LEN_W'(idx_ff) + LEN_W'(1);
      idx_next = (idx_step >= LEN_FULL) ? '0 : idx_step[IDX_W-1:0];

      if (draw) begin
         idx_in = idx_next;
      end else if (is_msg && first) begin
         idx_in = '0;
      end else begin
         idx_in = idx_ff;
      end

      // running key
      if (pos_cur == '0) begin
         key_mid = challenge_ff ^ value;
      end else if ((pos_cur == POS_W'(rkx_pkg::SEED_MIX_POS)) &&
                   (mode_ff == rkx_pkg::MODE_ENCODE)) begin
         key_mid = key_ff ^ value;
      end else begin
         key_mid = key_ff;
      end
      k_shift = pos_cur[0] ? {k[rkx_pkg::BYTE_W-2:0], 1'b0} : k;
      key_out = draw ? (key_mid ^ k_shift) : key_mid;
      key_in  = is_msg ? key_out : key_ff;

      res_byte = draw ? (value ^ key_out) : value;

      // saturating position
      if (is_msg) begin
         pos_in = (pos_cur < POS_MAX) ? pos_cur + POS_W'(1) : pos_cur;
      end else begin
         pos_in = pos_ff;
      end
      start_in = is_msg ? start_cur : start_ff;
   end

   // read the entry the next draw will need
   assign mem_rd_addr = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rkx_pkg::MODE_ENCODE;
         challenge_ff <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         key_ff       <= '0;
         pos_ff       <= '0;
         start_ff     <= rkx_pkg::START_W'(rkx_pkg::ENCODE_HEADER_BYTES);
      end else begin
         mode_ff      <= mode_in;
         challenge_ff <= challenge_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(idx_ff) < LEN_FULL)
      else $error("string index out of range");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("key string length over capacity");

   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == rkx_pkg::OP_LOAD) && first) |=> (len_ff == LEN_W'(1)))
      else $error("new key string did not restart length");

   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == rkx_pkg::OP_MSG) && first) |=> (pos_ff == POS_W'(1)) && (idx_ff == '0))
      else $error("new message did not restart position and index");

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position past saturation");

endmodule

### hw/rtl/rolling_key_xor_packet_scrambler_top.sv
`timescale 1ns / 1ps
// Top level of the rolling-key XOR packet scrambler.
//
// Use:
//  - csr_ port: write mode (index 0, 0 encode / 1 decode) and challenge
//    (index 1) while the block is idle. Writes take effect at the edge.
//  - req_ channel: op 0 items load key-string bytes (first restarts the
//    string) and give no result. op 1 items are message bytes; first starts
//    a new message and samples start_skip in decode mode.
//  - rsp_ channel: one item per message byte, result_last copies final_req.
// Latency: a message byte's result is valid the cycle after acceptance.
// One item per cycle unless stalled. The key string sits in a single-port-read
//  memory whose registered read data always holds the entry at the current
//  string index; the next index is computed from it in the same cycle.
// Reset (synchronous): key string length, index, running key, position and
//  registers clear, start position returns to the encode header length. The
//  key memory itself is not cleared; entries past the loaded length are
//  never used.
// Stall: a single output register holds the result; req_ready stays high
//  while that register is empty or being taken, so a stalled receiver backs
//  the input up after one item.
module rolling_key_xor_packet_scrambler_top #(
   parameter int KEY_STRING_BYTES  = rkx_pkg::KEY_STRING_BYTES_DEF,
   parameter int MAX_MESSAGE_BYTES = rkx_pkg::MAX_MESSAGE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [rkx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rkx_pkg::BYTE_W-1:0]    csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [rkx_pkg::BYTE_W-1:0]    req_value,
   input  logic                          req_first,
   input  logic                          req_final_req,
   input  logic [rkx_pkg::SKIP_W-1:0]    req_start_skip,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rkx_pkg::BYTE_W-1:0]    rsp_result_byte,
   output logic                          rsp_result_last
);

   localparam int IDX_W = $clog2(KEY_STRING_BYTES);

   logic                        accept;
   logic [rkx_pkg::BYTE_W-1:0]  res_byte;
   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_addr;
   logic [rkx_pkg::BYTE_W-1:0]  mem_wr_data;
   logic [IDX_W-1:0]            mem_rd_addr;
   logic [rkx_pkg::BYTE_W-1:0]  mem_rd_data;
   logic [rkx_pkg::BYTE_W-1:0]  mem_key0;

   // output stage
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rkx_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        out_load;

   // free to accept when the output register is empty or draining this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rkx_cipher_core #(
      .KEY_STRING_BYTES  (KEY_STRING_BYTES),
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .op          (req_op),
      .value       (req_value),
      .first       (req_first),
      .start_skip  (req_start_skip),
      .res_byte    (res_byte),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_key0    (mem_key0)
   );

   rkx_key_store #(
      .KEY_STRING_BYTES (KEY_STRING_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .key0    (mem_key0)
   );

   // only message bytes produce a result item
   always_comb begin
      out_load     = accept && (req_op == rkx_pkg::OP_MSG);
      rsp_byte_in  = out_load ? res_byte : rsp_byte_ff;
      rsp_last_in  = out_load ? req_final_req : rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_result_last = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("held item would be overwritten");

   a_msg_gives_item: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == rkx_pkg::OP_MSG)) |=> rsp_valid_ff)
      else $error("message byte gave no item");

   a_load_no_item: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == rkx_pkg::OP_LOAD) && rsp_ready) |=> !rsp_valid_ff)
      else $error("key load produced an item");

endmodule
